FILE: rtl/core/r2fft_pkg.sv
// r2fft_pkg: constants, types and twiddle rom for the radix-2 frame fft
// used by r2fft_bfly and radix2_fft_frame
package r2fft_pkg;

  localparam int unsigned NPointsDef = 64;
  localparam int unsigned MaxPoints  = 64;
  localparam int unsigned SampleW    = 16;
  localparam int unsigned BinW       = 22;
  localparam int unsigned AccW       = 24;
  localparam int unsigned TwW        = 17;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD,
    ST_MUL,
    ST_WR,
    ST_OUT_RD,
    ST_OUT
  } state_e;

  // quarter-wave cosine table, 2^15 scale
  function automatic logic signed [TwW-1:0] cos_q(input logic [4:0] k);
    logic signed [TwW-1:0] r;
    begin
      case (k)
        5'd0:  r = 17'sd32768;
        5'd1:  r = 17'sd32610;
        5'd2:  r = 17'sd32138;
        5'd3:  r = 17'sd31357;
        5'd4:  r = 17'sd30274;
        5'd5:  r = 17'sd28899;
        5'd6:  r = 17'sd27246;
        5'd7:  r = 17'sd25330;
        5'd8:  r = 17'sd23170;
        5'd9:  r = 17'sd20788;
        5'd10: r = 17'sd18205;
        5'd11: r = 17'sd15447;
        5'd12: r = 17'sd12540;
        5'd13: r = 17'sd9512;
        5'd14: r = 17'sd6393;
        5'd15: r = 17'sd3212;
        default: r = 17'sd0;
      endcase
      return r;
    end
  endfunction

  // twiddle for angle 2*pi*k/64: wr = cos, wi = -sin
  typedef struct packed {
    logic signed [TwW-1:0] wr;
    logic signed [TwW-1:0] wi;
  } twid_t;

  function automatic twid_t twiddle(input logic [4:0] k);
    twid_t t;
    begin
      if (k <= 5'd16) begin
        t.wr = cos_q(k);
        t.wi = -cos_q(5'd16 - k);
      end else begin
        t.wr = -cos_q(5'(6'd32 - {1'b0, k}));
        t.wi = -cos_q(k - 5'd16);
      end
      return t;
    end
  endfunction

endpackage

FILE: rtl/core/r2fft_ram.sv
// r2fft_ram: generic single-write, single-read ram with registered read
// no dependencies
module r2fft_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/core/r2fft_bfly.sv
// r2fft_bfly: shared complex multiply and add/subtract butterfly unit
// depends on r2fft_pkg; multiply registered, then round and add
module r2fft_bfly (
  input  logic                                clk_i,
  input  logic signed [r2fft_pkg::AccW-1:0]   ore_i,
  input  logic signed [r2fft_pkg::AccW-1:0]   oim_i,
  input  r2fft_pkg::twid_t                    tw_i,
  input  logic signed [r2fft_pkg::AccW-1:0]   ere_i,
  input  logic signed [r2fft_pkg::AccW-1:0]   eim_i,
  output logic signed [r2fft_pkg::AccW-1:0]   are_o,
  output logic signed [r2fft_pkg::AccW-1:0]   aim_o,
  output logic signed [r2fft_pkg::AccW-1:0]   bre_o,
  output logic signed [r2fft_pkg::AccW-1:0]   bim_o
);

  localparam int unsigned PW = r2fft_pkg::AccW + r2fft_pkg::TwW + 1;

  logic signed [PW-1:0] pr_q, pi_q;
  logic signed [PW-1:0] rr, ri;

  // operands sign-extended to the product width before multiplying
  always_ff @(posedge clk_i) begin
    pr_q <= PW'(tw_i.wr) * PW'(ore_i) - PW'(tw_i.wi) * PW'(oim_i);
    pi_q <= PW'(tw_i.wr) * PW'(oim_i) + PW'(tw_i.wi) * PW'(ore_i);
  end

  // round half up, arithmetic shift floors
  assign rr = (pr_q + PW'(16384)) >>> 15;
  assign ri = (pi_q + PW'(16384)) >>> 15;

  assign are_o = ere_i + rr[r2fft_pkg::AccW-1:0];
  assign aim_o = eim_i + ri[r2fft_pkg::AccW-1:0];
  assign bre_o = ere_i - rr[r2fft_pkg::AccW-1:0];
  assign bim_o = eim_i - ri[r2fft_pkg::AccW-1:0];

endmodule

FILE: rtl/core/radix2_fft_frame.sv
// radix2_fft_frame: frame-based radix-2 dit fft, top level with sequencer
// depends on r2fft_pkg, r2fft_ram, r2fft_bfly
// sequence: n load requests, then n/2*log2 n butterflies, each read, multiplied and
// written back on one shared unit and one ram, then each bin is read and streamed out
// frames: the next frame loads only once the last bin is registered; not ready while computing
// reset: asynchronous active low, clears the sequencer and sample count
module radix2_fft_frame #(
  parameter int unsigned NPoints = r2fft_pkg::NPointsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // sample_re[15:0], sample_im[31:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // bin_re[21:0], bin_im[43:22], bin_index[49:44], pad
  output logic        m_axis_tlast    // last_bin
);

  localparam int unsigned AW   = $clog2(r2fft_pkg::MaxPoints);
  localparam int unsigned LogN = $clog2(NPoints);
  localparam int unsigned AccW = r2fft_pkg::AccW;
  localparam int unsigned DW   = 2 * AccW;
  localparam logic [AW-1:0] LastIdx = AW'(NPoints - 1);

  r2fft_pkg::state_e state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;     // sample count / output bin
  logic [AW-1:0] half_q, half_d;   // half span of current stage
  logic [AW-1:0] j_q, j_d;         // index within group
  logic [AW-1:0] base_q, base_d;   // group base
  logic [2:0]    bph_q, bph_d;     // butterfly phase
  logic          ovld_q, ovld_d;
  logic signed [AccW-1:0] ore_q, oim_q, ere_q, eim_q;

  // bit-reversed write address on load, frame is stored in transform order
  logic [AW-1:0] rev;
  always_comb begin
    rev = '0;
    for (int b = 0; b < LogN; b++) begin
      rev[LogN-1-b] = cnt_q[b];
    end
  end

  logic [AW-1:0] aidx, oidx;
  assign aidx = base_q + j_q;
  assign oidx = base_q + j_q + half_q;

  // twiddle index j * (64 / m) = j * 32 / half
  logic [AW-1:0] tk;
  always_comb begin
    tk = '0;
    for (int s = 0; s < AW; s++) begin
      if (half_q == AW'(1 << s)) tk = AW'(j_q << (5 - s));
    end
  end

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;

  r2fft_ram #(.Width(DW), .Depth(r2fft_pkg::MaxPoints)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  logic signed [AccW-1:0] are, aim, bre, bim;
  r2fft_pkg::twid_t tw_q;

  r2fft_bfly u_bfly (
    .clk_i(clk_i),
    .ore_i(ore_q), .oim_i(oim_q), .tw_i(tw_q),
    .ere_i(ere_q), .eim_i(eim_q),
    .are_o(are), .aim_o(aim), .bre_o(bre), .bim_o(bim)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= r2fft_pkg::ST_LOAD;
      cnt_q   <= '0;
      half_q  <= '0;
      j_q     <= '0;
      base_q  <= '0;
      bph_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      half_q  <= half_d;
      j_q     <= j_d;
      base_q  <= base_d;
      bph_q   <= bph_d;
      ovld_q  <= ovld_d;
    end
  end

  // operand capture from the single read port
  always_ff @(posedge clk_i) begin
    tw_q <= r2fft_pkg::twiddle(tk[4:0]);
    if (state_q == r2fft_pkg::ST_RD && bph_q == 3'd1) begin
      ore_q <= rdata[AccW-1:0];
      oim_q <= rdata[DW-1:AccW];
    end
    if (state_q == r2fft_pkg::ST_RD && bph_q == 3'd2) begin
      ere_q <= rdata[AccW-1:0];
      eim_q <= rdata[DW-1:AccW];
    end
  end

  logic s_acc, m_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    half_d  = half_q;
    j_d     = j_q;
    base_d  = base_q;
    bph_d   = bph_q;
    ovld_d  = ovld_q;
    we      = 1'b0;
    waddr   = rev;
    wdata   = {{(AccW-r2fft_pkg::SampleW){s_axis_tdata[31]}}, s_axis_tdata[31:16],
               {(AccW-r2fft_pkg::SampleW){s_axis_tdata[15]}}, s_axis_tdata[15:0]};
    raddr   = oidx;
    s_axis_tready = 1'b0;
    unique case (state_q)
      r2fft_pkg::ST_LOAD: begin
        s_axis_tready = 1'b1;
        we = s_acc;
        if (s_acc) begin
          if (cnt_q == LastIdx) begin
            cnt_d   = '0;
            half_d  = AW'(1);
            j_d     = '0;
            base_d  = '0;
            bph_d   = '0;
            state_d = r2fft_pkg::ST_RD;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      r2fft_pkg::ST_RD: begin
        // phase 0 reads odd, phase 1 reads even, phase 2 captures even
        raddr = (bph_q == 3'd0) ? oidx : aidx;
        bph_d = bph_q + 1'b1;
        if (bph_q == 3'd2) begin
          bph_d   = '0;
          state_d = r2fft_pkg::ST_MUL;
        end
      end
      r2fft_pkg::ST_MUL: begin
        state_d = r2fft_pkg::ST_WR;
      end
      r2fft_pkg::ST_WR: begin
        we = 1'b1;
        if (bph_q == 3'd0) begin
          waddr = aidx;
          wdata = {aim, are};
          bph_d = 3'd1;
        end else begin
          waddr = oidx;
          wdata = {bim, bre};
          bph_d = '0;
          state_d = r2fft_pkg::ST_RD;
          if (j_q + 1'b1 != half_q) begin
            j_d = j_q + 1'b1;
          end else begin
            j_d = '0;
            if ({1'b0, base_q} + {half_q, 1'b0} < (AW+1)'(NPoints)) begin
              base_d = base_q + {half_q[AW-2:0], 1'b0};
            end else begin
              base_d = '0;
              if ({1'b0, half_q, 1'b0} == (AW+2)'(NPoints)) begin
                cnt_d   = '0;
                state_d = r2fft_pkg::ST_OUT_RD;
              end else begin
                half_d = {half_q[AW-2:0], 1'b0};
              end
            end
          end
        end
      end
      r2fft_pkg::ST_OUT_RD: begin
        raddr = cnt_q;
        if (!ovld_q || m_acc) begin
          ovld_d  = 1'b0;
          state_d = r2fft_pkg::ST_OUT;
        end
      end
      r2fft_pkg::ST_OUT: begin
        raddr = cnt_q;
        if (!ovld_q) begin
          ovld_d = 1'b1;
          if (cnt_q == LastIdx) begin
            cnt_d   = '0;
            state_d = r2fft_pkg::ST_LOAD;
          end else begin
            cnt_d   = cnt_q + 1'b1;
            state_d = r2fft_pkg::ST_OUT_RD;
          end
        end else if (m_acc) begin
          ovld_d = 1'b0;
        end
      end
      default: state_d = r2fft_pkg::ST_LOAD;
    endcase
    if (state_q != r2fft_pkg::ST_OUT && m_acc) begin
      ovld_d = 1'b0;
    end
    if (state_q == r2fft_pkg::ST_OUT_RD && m_acc) begin
      ovld_d = 1'b0;
    end
  end

  // output register, saturated to 22 bits
  function automatic logic [r2fft_pkg::BinW-1:0] sat(input logic signed [AccW-1:0] v);
    if (v > AccW'(2097151)) return 22'h1FFFFF;
    if (v < -AccW'(2097152)) return 22'h200000;
    return v[r2fft_pkg::BinW-1:0];
  endfunction

  logic [r2fft_pkg::BinW-1:0] ore_out_q, oim_out_q;
  logic [AW-1:0] oidx_q;
  logic olast_q;

  always_ff @(posedge clk_i) begin
    if (state_q == r2fft_pkg::ST_OUT && !ovld_q) begin
      ore_out_q <= sat(rdata[AccW-1:0]);
      oim_out_q <= sat(rdata[DW-1:AccW]);
      oidx_q    <= cnt_q;
      olast_q   <= (cnt_q == LastIdx);
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {6'b0, oidx_q, oim_out_q, ore_out_q};
  assign m_axis_tlast  = olast_q;

  // input ready outside the load state only while no bin is waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid || state_q == r2fft_pkg::ST_LOAD)
    else $error("load overlaps output");
  // last bin carries the top index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> oidx_q == LastIdx)
    else $error("last flag on wrong bin");
  // no writes to the frame store while bins are streamed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == r2fft_pkg::ST_OUT || state_q == r2fft_pkg::ST_OUT_RD) |-> !we)
    else $error("store written during output");

endmodule
